/* rtl/debug_packet_receive_deframer_macros.svh */
`ifndef DEBUG_PACKET_RECEIVE_DEFRAMER_MACROS_SVH
`define DEBUG_PACKET_RECEIVE_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DPRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DPRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dprd_pkg.sv */
package dprd_pkg;

  localparam logic [7:0] BYTE_ACK   = 8'h2B;
  localparam logic [7:0] BYTE_NACK  = 8'h2D;
  localparam logic [7:0] BYTE_BREAK = 8'h03;
  localparam logic [7:0] BYTE_START = 8'h24;
  localparam logic [7:0] BYTE_END   = 8'h23;

  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_GOOD  = 3'd1,
    EV_BAD   = 3'd2,
    EV_RETX  = 3'd3,
    EV_BREAK = 3'd4,
    EV_FRAME = 3'd5
  } event_t;

  typedef struct packed {
    logic        valid;
    event_t      ev;
    logic [7:0]  data;
    logic [7:0]  csum;
    logic [7:0]  rsum;
  } result_t;

  // {is_hex, nibble}; a non-hex character decodes as nibble zero
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

/* rtl/dprd_parser.sv */
`include "debug_packet_receive_deframer_macros.svh"

module dprd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [7:0]           rx_byte,
  output dprd_pkg::result_t    res
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [3:0]  high_r, high_nxt;
  logic        seen_r, seen_nxt;
  logic        bad_digit_r, bad_digit_nxt;
  logic [4:0]  hex;
  logic [7:0]  rsum;

  assign hex  = dprd_pkg::hex_decode(rx_byte);
  assign rsum = {high_r, hex[3:0]};

  always_comb begin
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    high_nxt      = high_r;
    seen_nxt      = seen_r;
    bad_digit_nxt = bad_digit_r;
    res           = '0;
    res.ev        = dprd_pkg::EV_DATA;
    unique case (phase_r)
      PH_PAYLOAD: begin
        if (rx_byte == dprd_pkg::BYTE_END) begin
          phase_nxt     = PH_CHECK;
          seen_nxt      = 1'b0;
          bad_digit_nxt = 1'b0;
          high_nxt      = 4'd0;
        end else begin
          sum_nxt   = sum_r + rx_byte;
          res.valid = 1'b1;
          res.ev    = dprd_pkg::EV_DATA;
          res.data  = rx_byte;
        end
      end
      PH_CHECK: begin
        if (!hex[4]) begin
          bad_digit_nxt = 1'b1;
        end
        if (!seen_r) begin
          high_nxt = hex[3:0];
          seen_nxt = 1'b1;
        end else begin
          res.valid = 1'b1;
          res.csum  = sum_r;
          res.rsum  = rsum;
          res.ev    = (!bad_digit_r && hex[4] && rsum == sum_r) ?
                      dprd_pkg::EV_GOOD : dprd_pkg::EV_BAD;
          // end of packet: back to idle, clean slate
          phase_nxt     = PH_IDLE;
          sum_nxt       = 8'd0;
          high_nxt      = 4'd0;
          seen_nxt      = 1'b0;
          bad_digit_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        priority if (rx_byte == dprd_pkg::BYTE_ACK) begin
          // ignore
        end else if (rx_byte == dprd_pkg::BYTE_NACK) begin
          res.valid = 1'b1;
          res.ev    = dprd_pkg::EV_RETX;
        end else if (rx_byte == dprd_pkg::BYTE_BREAK) begin
          res.valid = 1'b1;
          res.ev    = dprd_pkg::EV_BREAK;
        end else if (rx_byte == dprd_pkg::BYTE_START) begin
          phase_nxt     = PH_PAYLOAD;
          sum_nxt       = 8'd0;
          high_nxt      = 4'd0;
          seen_nxt      = 1'b0;
          bad_digit_nxt = 1'b0;
        end else begin
          res.valid = 1'b1;
          res.ev    = dprd_pkg::EV_FRAME;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sum_r       <= 8'd0;
      high_r      <= 4'd0;
      seen_r      <= 1'b0;
      bad_digit_r <= 1'b0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      high_r      <= high_nxt;
      seen_r      <= seen_nxt;
      bad_digit_r <= bad_digit_nxt;
    end
  end

  `DPRD_ASSERT_NOW(a_good_sums_match, res.valid && res.ev == dprd_pkg::EV_GOOD, res.csum == res.rsum, "good packet reported with differing sums")
  `DPRD_ASSERT_NOW(a_data_only_payload, res.valid && res.ev != dprd_pkg::EV_DATA, res.data == 8'd0, "payload byte on a non-payload event")
  `DPRD_ASSERT_NEXT(a_idle_after_end, en && res.valid && (res.ev == dprd_pkg::EV_GOOD || res.ev == dprd_pkg::EV_BAD), phase_r == PH_IDLE && sum_r == 8'd0 && !seen_r, "packet end did not clear state")
  `DPRD_ASSERT_NEXT(a_hold_when_off, !en, $stable(phase_r) && $stable(sum_r), "state moved without a word")

endmodule

/* rtl/debug_packet_receive_deframer.sv */
// Debug-link packet deframer. Takes one received byte per cycle and parses
// '$' payload '#' h l packets: each payload byte comes out as it arrives,
// and after the two checksum digits a good or bad packet event carries the
// computed and received sums. Outside a packet '+' is dropped, '-' gives a
// retransmit event, 0x03 a break event, and anything else a framing error.
// A byte is taken every cycle while the result side keeps up. The byte is
// held in the input register until the result register is free or being
// emptied, and its result is then loaded into the result register, so the
// outputs are registered. out_stall reaches in_stall combinationally
// through the single input stage.
`include "debug_packet_receive_deframer_macros.svh"

module debug_packet_receive_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_data,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               adv;
  logic               en;
  dprd_pkg::result_t  res;
  logic               out_valid_r;
  dprd_pkg::event_t   out_ev_r;
  logic [7:0]         out_data_r;
  logic [7:0]         out_csum_r;
  logic [7:0]         out_rsum_r;

  // result register free, or being emptied this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign en       = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  dprd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= en && res.valid;
      end
    end
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
    if (en && res.valid) begin
      out_ev_r   <= res.ev;
      out_data_r <= res.data;
      out_csum_r <= res.csum;
      out_rsum_r <= res.rsum;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_payload_data = out_data_r;
  assign out_computed_sum = out_csum_r;
  assign out_received_sum = out_rsum_r;

  `DPRD_ASSERT_NEXT(a_s1_held, s1_valid_r && !adv, s1_valid_r && $stable(s1_byte_r),
                    "input word lost under stall")
  `DPRD_ASSERT_NOW(a_no_stall_empty, !s1_valid_r, !in_stall,
                   "stall raised with empty input stage")

endmodule
